// ===== rtl/gaqi_pkg.sv =====
package gaqi_pkg;

	localparam int GAS_IN_W      = 24;
	localparam int HUM_W         = 16;
	localparam int IAQ_W         = 13;
	localparam int BASE_OUT_W    = 24;
	localparam int GAIN_W        = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int GAS_BITS_DEF  = 24;
	localparam int FRAC_BITS_DEF = 16;

	localparam int RATIO_FRAC_W = 16;
	localparam int RATIO_W      = RATIO_FRAC_W + 1;
	localparam int STEP_CNT_W   = $clog2(GAIN_W);
	localparam int HUM_RECIP_W  = 32;
	localparam int HUM_RECIP_SH = 17;
	localparam int HUM_SCORE_W  = 27;
	localparam int SCORE_W      = 29;
	localparam int SCORE_FRAC_W = 16;
	localparam int HUM_M_W      = 13;

	localparam logic [GAIN_W-1:0] RISE_GAIN_RESET  = 16'd6554;
	localparam logic [GAIN_W-1:0] DECAY_GAIN_RESET = 16'd33;

	localparam logic signed [HUM_W-1:0] HUM_LOW_EDGE  = 16'sd3800;
	localparam logic signed [HUM_W-1:0] HUM_HIGH_EDGE = 16'sd4200;
	localparam logic signed [HUM_W-1:0] HUM_TOP       = 16'sd10000;

	localparam logic [HUM_RECIP_W-1:0] HUM_LOW_RECIP  = 32'd2825636379;
	localparam logic [HUM_RECIP_W-1:0] HUM_HIGH_RECIP = 32'd1851279007;
	localparam logic [HUM_SCORE_W-1:0] HUM_FULL       = 27'd81920000;

	localparam logic [RATIO_W-1:0]   RATIO_ONE  = 17'h10000;
	localparam logic [11:0]          GAS_WEIGHT = 12'd3750;
	localparam logic [SCORE_W-1:0]   IAQ_TOP    = 29'd327680000;
	localparam logic [SCORE_W:0]     ROUND_HALF = 30'd32768;
	localparam logic [IAQ_W-1:0]     IAQ_MAX    = 13'd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_GAIN  = 2'd0,
		REG_DECAY_GAIN = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_DIV,
		ST_RATIO,
		ST_SCORE,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic upd;
		logic div_step;
		logic ratio_load;
		logic score_load;
		logic out_load;
	} ctrl_cmd_t;

endpackage

// ===== rtl/gas_air_quality_index_core.sv =====
// Air quality index core: each transfer on the input channel delivers one gas resistance
// sample and one humidity reading, and one result with the index and the updated clean-air
// baseline is then placed in the output register. The work runs in order through a
// shift-and-add multiply for the baseline step, an update of the baseline, a restoring divide
// for the gas ratio, and steps to load the ratio, the score and the result; the result waits
// until the output register is free. The humidity score comes from a constant reciprocal
// multiply and is combinational. One sample is in work at a time, so no new sample is taken
// before the last one is through; the next is taken as soon as the previous result sits in
// the output register, which holds it until the receiver takes it. Configuration writes are
// always ready and should be made only while the block is idle.
module gas_air_quality_index_core import gaqi_pkg::*; #(
	parameter int GAS_BITS  = GAS_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [GAS_IN_W-1:0]     gas_ohms,
	input  logic signed [HUM_W-1:0] humidity_centi,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IAQ_W-1:0]        iaq_tenths,
	output logic [BASE_OUT_W-1:0]   baseline_ohms,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [GAIN_W-1:0]       cfg_data
);

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	gaqi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	gaqi_datapath #(
		.GAS_BITS  (GAS_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.gas_ohms       (gas_ohms),
		.humidity_centi (humidity_centi),
		.iaq_tenths     (iaq_tenths),
		.baseline_ohms  (baseline_ohms)
	);

endmodule

// ===== rtl/gaqi_ctrl.sv =====
module gaqi_ctrl import gaqi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ctrl_cmd_t cmd
);

	ctrl_state_t             state_q, state_d;
	logic [STEP_CNT_W-1:0]   cnt_q;
	logic                    out_valid_q;
	logic                    cnt_last;
	logic                    out_free;

	assign cnt_last  = (cnt_q == STEP_CNT_W'(GAIN_W - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul_step || cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_last) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_last) begin
					state_d = ST_RATIO;
				end
			end
			ST_RATIO: begin
				cmd.ratio_load = 1'b1;
				state_d        = ST_SCORE;
			end
			ST_SCORE: begin
				cmd.score_load = 1'b1;
				state_d        = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/gaqi_datapath.sv =====
module gaqi_datapath import gaqi_pkg::*; #(
	parameter int GAS_BITS  = GAS_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctrl_cmd_t                  cmd,
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [GAIN_W-1:0]          cfg_data,
	input  logic [GAS_IN_W-1:0]        gas_ohms,
	input  logic signed [HUM_W-1:0]    humidity_centi,
	output logic [IAQ_W-1:0]           iaq_tenths,
	output logic [BASE_OUT_W-1:0]      baseline_ohms
);

	localparam int BASE_W = GAS_BITS + FRAC_BITS;
	localparam int ACC_W  = BASE_W + GAIN_W;
	localparam int HPROD_W = HUM_M_W + HUM_RECIP_W;

	typedef enum logic [1:0] {
		HUM_ZERO,
		HUM_FULL_BAND,
		HUM_RAMP
	} hum_mode_t;

	logic [GAIN_W-1:0] rise_q, decay_q;
	logic [BASE_W-1:0] base_q;

	logic [BASE_W-1:0] gq_q, diff_q, rem_q;
	logic              seed_q, up_q;
	logic [ACC_W-1:0]  acc_q;
	logic [GAIN_W-1:0] gain_q;
	logic [RATIO_FRAC_W-1:0] quo_q;
	logic [RATIO_W-1:0]      ratio_q;
	logic [SCORE_W-1:0]      sub_q;
	hum_mode_t               hmode_q;
	logic [HUM_M_W-1:0]      hum_m_q;
	logic                    hhigh_q;
	logic [IAQ_W-1:0]        iaq_q;
	logic [BASE_OUT_W-1:0]   base_out_q;

	logic [GAS_BITS+GAS_IN_W-1:0] gas_ext;
	logic [GAS_BITS-1:0]          gas_sat;
	logic [BASE_W-1:0]            gq, diff, one_q, step, base_new, base_floor;
	logic                         up;
	hum_mode_t                    hmode;
	logic [HUM_M_W-1:0]           hum_m;
	logic                         hhigh;
	logic [HPROD_W-1:0]           hum_prod;
	logic [BASE_W:0]              rt;
	logic                         rge;
	logic [BASE_W-1:0]            rem_next;
	logic [HUM_SCORE_W-1:0]       hum_score;
	logic [SCORE_W-1:0]           total;
	logic [SCORE_W:0]             rounded;
	logic [SCORE_W-SCORE_FRAC_W:0] iaq_full;
	logic [GAS_BITS-1:0]          base_int;
	logic [GAS_BITS+BASE_OUT_W-1:0] base_ext;

	assign gas_ext = (GAS_BITS + GAS_IN_W)'(gas_ohms);
	assign gas_sat = (|(gas_ext >> GAS_BITS)) ? '1 : gas_ext[GAS_BITS-1:0];
	assign gq      = BASE_W'(gas_sat) << FRAC_BITS;
	assign up      = (gq > base_q);
	assign diff    = up ? (gq - base_q) : (base_q - gq);
	assign one_q   = BASE_W'(1) << FRAC_BITS;

	always_comb begin
		hmode = HUM_ZERO;
		hum_m = '0;
		hhigh = 1'b0;
		if ((humidity_centi >= HUM_LOW_EDGE) && (humidity_centi <= HUM_HIGH_EDGE)) begin
			hmode = HUM_FULL_BAND;
		end else if ((humidity_centi > 16'sd0) && (humidity_centi < HUM_LOW_EDGE)) begin
			hmode = HUM_RAMP;
			hum_m = HUM_M_W'(humidity_centi);
		end else if ((humidity_centi > HUM_HIGH_EDGE) && (humidity_centi < HUM_TOP)) begin
			hmode = HUM_RAMP;
			hum_m = HUM_M_W'(HUM_TOP - humidity_centi);
			hhigh = 1'b1;
		end
	end

	assign hum_prod = HPROD_W'(hum_m_q) *
		HPROD_W'(hhigh_q ? HUM_HIGH_RECIP : HUM_LOW_RECIP);

	assign rt       = {rem_q, 1'b0};
	assign rge      = (rt >= (BASE_W + 1)'(base_q));
	assign rem_next = rge ? BASE_W'(rt - (BASE_W + 1)'(base_q)) : rt[BASE_W-1:0];

	assign step       = acc_q[ACC_W-1:GAIN_W];
	assign base_new   = seed_q ? gq_q : (up_q ? (base_q + step) : (base_q - step));
	assign base_floor = (base_new < one_q) ? one_q : base_new;

	always_comb begin
		unique case (hmode_q)
			HUM_FULL_BAND: hum_score = HUM_FULL;
			HUM_RAMP:      hum_score = hum_prod[HUM_RECIP_SH +: HUM_SCORE_W];
			default:       hum_score = '0;
		endcase
	end

	assign total    = (sub_q >= IAQ_TOP) ? '0 : (IAQ_TOP - sub_q);
	assign rounded  = (SCORE_W + 1)'(total) + ROUND_HALF;
	assign iaq_full = rounded[SCORE_W:SCORE_FRAC_W];

	assign base_int = base_q[BASE_W-1:FRAC_BITS];
	assign base_ext = (GAS_BITS + BASE_OUT_W)'(base_int);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q  <= RISE_GAIN_RESET;
			decay_q <= DECAY_GAIN_RESET;
			base_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RISE_GAIN:  rise_q  <= cfg_data;
					REG_DECAY_GAIN: decay_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.upd) begin
				base_q <= base_floor;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gq_q    <= gq;
			seed_q  <= (base_q == '0);
			up_q    <= up;
			diff_q  <= diff;
			acc_q   <= '0;
			gain_q  <= up ? rise_q : decay_q;
			hmode_q <= hmode;
			hum_m_q <= hum_m;
			hhigh_q <= hhigh;
		end
		if (cmd.mul_step) begin
			acc_q  <= (acc_q << 1) + (gain_q[GAIN_W-1] ? ACC_W'(diff_q) : '0);
			gain_q <= gain_q << 1;
		end
		if (cmd.upd) begin
			rem_q <= gq_q;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[RATIO_FRAC_W-2:0], rge};
		end
		if (cmd.ratio_load) begin
			ratio_q <= (gq_q >= base_q) ? RATIO_ONE : RATIO_W'(quo_q);
		end
		if (cmd.score_load) begin
			sub_q <= SCORE_W'(hum_score) + SCORE_W'(ratio_q) * SCORE_W'(GAS_WEIGHT);
		end
		if (cmd.out_load) begin
			iaq_q      <= (iaq_full > (SCORE_W - SCORE_FRAC_W + 1)'(IAQ_MAX)) ?
				IAQ_MAX : IAQ_W'(iaq_full);
			base_out_q <= (|(base_ext >> BASE_OUT_W)) ? '1 : base_ext[BASE_OUT_W-1:0];
		end
	end

	assign iaq_tenths    = iaq_q;
	assign baseline_ohms = base_out_q;

endmodule

// ===== rtl/gaqi_checker.sv =====
module gaqi_checker import gaqi_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [IAQ_W-1:0]        iaq_tenths,
	input logic [BASE_OUT_W-1:0]   baseline_ohms
);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transfer");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared one cycle after the input transfer");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((iaq_tenths <= IAQ_MAX) && (baseline_ohms != '0)))
		else $error("result out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(iaq_tenths) && $stable(baseline_ohms)))
		else $error("stalled result changed");

endmodule

bind gas_air_quality_index_core gaqi_checker u_gaqi_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import gaqi_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

	localparam longint Q_ONE          = 65536;
	localparam longint HUM_SCORE_MAX  = 1250 * 65536;
	localparam longint IAQ_FULL_SCALE = 5000 * 65536;
	localparam longint GAS_SCORE_MUL  = 3750;
	localparam longint HUM_BAND_LO    = 3800;
	localparam longint HUM_BAND_HI    = 4200;
	localparam longint HUM_SATURATED  = 10000;
	localparam longint IAQ_CEILING    = 5000;
	localparam longint BASE_OUT_MAX   = 24'hFFFFFF;
	localparam int     GAS_OUT_MAX    = 24'hFFFFFF;

	typedef struct {
		logic [GAS_IN_W-1:0]     gas;
		logic signed [HUM_W-1:0] hum;
	} gas_sample_t;

	typedef struct {
		logic [IAQ_W-1:0]      iaq;
		logic [BASE_OUT_W-1:0] base;
	} iaq_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [GAS_IN_W-1:0]     gas_ohms = '0;
	logic signed [HUM_W-1:0] humidity_centi = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [IAQ_W-1:0]        iaq_tenths;
	logic [BASE_OUT_W-1:0]   baseline_ohms;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [GAIN_W-1:0]       cfg_data = '0;

	gas_sample_t pending_samples[$];
	iaq_result_t iaq_expected[$];

	longint      baseline_q = 0;
	longint      rise_w = 6554;
	longint      decay_w = 33;
	int          idle_pct = 6;
	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	gas_sample_t next_sample;
	iaq_result_t want;

	gas_air_quality_index_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.gas_ohms       (gas_ohms),
		.humidity_centi (humidity_centi),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.iaq_tenths     (iaq_tenths),
		.baseline_ohms  (baseline_ohms),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL gas_air_quality_index_core");
		$finish;
	end

	function automatic longint hum_score(input logic signed [HUM_W-1:0] hum);
		longint hv;
		hv = hum;
		if (hv >= HUM_BAND_LO && hv <= HUM_BAND_HI)
			return HUM_SCORE_MAX;
		if (hv < HUM_BAND_LO) begin
			if (hv <= 0)
				return 0;
			return (hv * HUM_SCORE_MAX) / HUM_BAND_LO;
		end
		if (hv >= HUM_SATURATED)
			return 0;
		return ((HUM_SATURATED - hv) * HUM_SCORE_MAX) / (HUM_SATURATED - HUM_BAND_LO - 400);
	endfunction

	function automatic iaq_result_t predict_iaq(input logic [GAS_IN_W-1:0] gas,
			input logic signed [HUM_W-1:0] hum);
		longint      gq;
		longint      ratio;
		longint      sub;
		longint      total;
		longint      iaqv;
		longint      base_int;
		iaq_result_t r;
		gq = longint'(gas) << 16;
		if (baseline_q == 0)
			baseline_q = gq;
		else if (gq > baseline_q)
			baseline_q = baseline_q + (((gq - baseline_q) * rise_w) >> 16);
		else
			baseline_q = baseline_q - (((baseline_q - gq) * decay_w) >> 16);
		if (baseline_q < Q_ONE)
			baseline_q = Q_ONE;
		ratio = (gq >= baseline_q) ? Q_ONE : (gq << 16) / baseline_q;
		sub = hum_score(hum) + ratio * GAS_SCORE_MUL;
		total = (sub >= IAQ_FULL_SCALE) ? 0 : IAQ_FULL_SCALE - sub;
		iaqv = (total + Q_ONE / 2) >> 16;
		if (iaqv > IAQ_CEILING)
			iaqv = IAQ_CEILING;
		base_int = baseline_q >> 16;
		if (base_int > BASE_OUT_MAX)
			base_int = BASE_OUT_MAX;
		r.iaq = iaqv[IAQ_W-1:0];
		r.base = base_int[BASE_OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			iaq_expected.push_back(predict_iaq(gas_ohms, humidity_centi));
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_sample = pending_samples.pop_front();
				in_valid <= 1'b1;
				gas_ohms <= next_sample.gas;
				humidity_centi <= next_sample.hum;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			results_seen++;
			if (iaq_expected.size() == 0) begin
				$error("unexpected transfer: iaq_tenths=%0d baseline_ohms=%0d",
					iaq_tenths, baseline_ohms);
				errors++;
			end else begin
				want = iaq_expected.pop_front();
				if (iaq_tenths !== want.iaq) begin
					$error("iaq_tenths: expected %0d, actual %0d", want.iaq, iaq_tenths);
					errors++;
				end
				if (baseline_ohms !== want.base) begin
					$error("baseline_ohms: expected %0d, actual %0d", want.base, baseline_ohms);
					errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen == 40) begin
			hold_done = 1'b1;
			hold_left = 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	task automatic push_sample(input logic [GAS_IN_W-1:0] gas, input logic signed [HUM_W-1:0] hum);
		gas_sample_t s;
		s.gas = gas;
		s.hum = hum;
		pending_samples.push_back(s);
	endtask

	task automatic push_random(input int count);
		logic [GAS_IN_W-1:0]     gas;
		logic signed [HUM_W-1:0] hum;
		repeat (count) begin
			case ($urandom_range(9))
				0: gas = GAS_IN_W'($urandom());
				1: gas = GAS_IN_W'($urandom_range(0, 255));
				2: gas = GAS_IN_W'(GAS_OUT_MAX - $urandom_range(0, 1000));
				default: gas = GAS_IN_W'($urandom_range(20000, 400000));
			endcase
			case ($urandom_range(9))
				0, 1: hum = HUM_W'($urandom());
				2: hum = HUM_W'($urandom_range(3700, 4300));
				default: hum = HUM_W'($urandom_range(0, 10000));
			endcase
			push_sample(gas, hum);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || in_valid || iaq_expected.size() != 0);
	endtask

	task automatic write_gain_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RISE_GAIN: rise_w = val;
			REG_DECAY_GAIN: decay_w = val;
			default: ;
		endcase
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		@(negedge clk);
		push_sample(24'd0, 16'sd0);
		push_sample(24'hFFFFFF, 16'sd3800);
		push_sample(24'hFFFFFF, 16'sd4200);
		push_sample(24'd1, 16'sd3799);
		push_sample(24'd0, 16'sd4201);
		push_sample(24'd12345, 16'sd9999);
		push_sample(24'd100000, 16'sd10000);
		push_sample(24'd100000, -16'sd1);
		push_sample(24'd5000, -16'sd32768);
		push_sample(24'd200000, 16'sd32767);
		push_sample(24'd200000, 16'sd1);
		push_sample(24'd150000, 16'sd4000);
		push_sample(24'd50000, 16'sd2500);
		push_sample(24'hFFFFFF, 16'sd7000);
		push_sample(24'd1, 16'sd5000);
		push_sample(24'hAAAAAA, 16'sh5555);
		push_sample(24'h555555, 16'shAAAA);
		push_sample(24'd300000, 16'sd3800);
		wait_idle();

		write_gain_reg(REG_RISE_GAIN, 16'd0);
		write_gain_reg(REG_DECAY_GAIN, 16'd0);
		write_gain_reg(REG_SPARE3, 16'hFFFF);
		@(negedge clk);
		push_random(100);
		wait_idle();

		write_gain_reg(REG_RISE_GAIN, 16'hFFFF);
		write_gain_reg(REG_DECAY_GAIN, 16'hFFFF);
		@(negedge clk);
		idle_pct = 0;
		push_random(150);
		wait_idle();
		idle_pct = 6;

		write_gain_reg(REG_RISE_GAIN, GAIN_W'($urandom()));
		write_gain_reg(REG_DECAY_GAIN, GAIN_W'($urandom()));
		@(negedge clk);
		push_random(150);
		wait_idle();

		write_gain_reg(REG_SPARE2, 16'd1);
		write_gain_reg(REG_RISE_GAIN, 16'd6554);
		write_gain_reg(REG_DECAY_GAIN, 16'd33);
		@(negedge clk);
		push_random(200);
		wait_idle();

		write_gain_reg(REG_RISE_GAIN, GAIN_W'($urandom()));
		write_gain_reg(REG_DECAY_GAIN, 16'hFFFF);
		@(negedge clk);
		push_random(150);
		wait_idle();

		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("PASS gas_air_quality_index_core");
		else
			$display("FAIL gas_air_quality_index_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gaqi_pkg.sv
rtl/gaqi_ctrl.sv
rtl/gaqi_datapath.sv
rtl/gas_air_quality_index_core.sv
rtl/gaqi_checker.sv
test/tb.sv
